// ===== rtl/rcgs_pkg.sv =====
package rcgs_pkg;

    // Grid and value limits.
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int VALUE_BITS = 16;

    // Index widths follow the grid limits.
    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int ROW_BITS = $clog2(MAX_ROWS);

    // Configuration register widths.
    localparam int CFG_SIZE_BITS = 11;
    localparam int GAIN_BITS     = 14;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = VALUE_BITS;

    // Smallest usable grid side and the register reset values.
    localparam int SIZE_MIN         = 3;
    localparam int ROWS_RESET       = 16;
    localparam int COLS_RESET       = 16;
    localparam int GAIN_RESET       = 13107;
    localparam int CORNER_RESET     = 5120;

    // Stencil arithmetic widths.
    localparam int FRAC_BITS  = 16;
    localparam int SUM_BITS   = VALUE_BITS + 2;
    localparam int LAP_BITS   = VALUE_BITS + 3;
    localparam int PROD_BITS  = LAP_BITS + GAIN_BITS + 1;
    localparam int DELTA_BITS = PROD_BITS - FRAC_BITS;
    localparam int RES_BITS   = DELTA_BITS + 1;

    // Request opcodes.
    typedef enum logic {
        OP_NODE  = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GRID_ROWS      = 2'd0,
        REG_GRID_COLS      = 2'd1,
        REG_STEP_GAIN      = 2'd2,
        REG_CORNER_VOLTAGE = 2'd3
    } t_cfg_reg;

    // Position of a node in the grid, with its border flags.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                top;
        logic                bot;
        logic                lft;
        logic                rgt;
        logic                last;
    } t_pos;

endpackage

// ===== rtl/rc_grid_stencil_step.sv =====
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// in        | input     | i_in_valid / o_in_ready    | i_opcode, i_node_value
// out       | output    | o_out_valid / i_out_ready  | o_new_value, o_out_row, o_out_col,
//           |           |                            | o_frame_last
// cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request is taken per cycle while o_in_ready is high. After the request that completes
// its window is accepted, a node result passes line buffer read, Laplacian, then the gain
// multiply with rounding and saturation, one register each, the last being the output register.
// The two line buffers are single-write, registered-read RAMs; they are not cleared at
// reset and hold meaningful data only once the first grid row has streamed in.
// Reset clears the counters and the pipeline valids and loads the configuration reset values.
// A stalled output backs up through the pipeline and drops o_in_ready.
module rc_grid_stencil_step
    import rcgs_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic signed [VALUE_BITS-1:0]   i_node_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [VALUE_BITS-1:0]   o_new_value,
    output logic [ROW_BITS-1:0]            o_out_row,
    output logic [COL_BITS-1:0]            o_out_col,
    output logic                           o_frame_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam logic signed [RES_BITS-1:0] SAT_HI =
        RES_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'sd1 <<< (FRAC_BITS - 1));

    // Configuration registers.
    logic [CFG_SIZE_BITS-1:0]       r_grid_rows;
    logic [CFG_SIZE_BITS-1:0]       r_grid_cols;
    logic [GAIN_BITS-1:0]           r_step_gain;
    logic signed [VALUE_BITS-1:0]   r_corner_voltage;

    // Frame counters and the window register.
    logic [ROW_BITS:0]              r_in_row,  n_in_row;
    logic [COL_BITS-1:0]            r_in_col,  n_in_col;
    logic [ROW_BITS-1:0]            r_out_row, n_out_row;
    logic [COL_BITS-1:0]            r_out_col, n_out_col;
    logic signed [VALUE_BITS-1:0]   r_window,  n_window;

    // Stage 1: line buffer read data arrives.
    logic                           r_s1_valid;
    logic                           r_s1_emit;
    t_pos                           r_s1_pos;
    logic signed [VALUE_BITS-1:0]   r_s1_val;
    logic signed [VALUE_BITS-1:0]   r_next_ctr;
    logic signed [VALUE_BITS-1:0]   r_prev_ctr;

    // Stage 2: Laplacian is registered.
    logic                           r_s2_valid;
    logic signed [LAP_BITS-1:0]     r_s2_lap;
    logic signed [VALUE_BITS-1:0]   r_s2_ctr;
    logic                           r_s2_corner;
    logic [ROW_BITS-1:0]            r_s2_row;
    logic [COL_BITS-1:0]            r_s2_col;
    logic                           r_s2_last;

    // Output register.
    logic                           r_o_valid;
    logic signed [VALUE_BITS-1:0]   r_o_value;
    logic [ROW_BITS-1:0]            r_o_row;
    logic [COL_BITS-1:0]            r_o_col;
    logic                           r_o_last;

    logic [CFG_SIZE_BITS-1:0]       rows_used;
    logic [CFG_SIZE_BITS-1:0]       cols_used;
    logic [ROW_BITS-1:0]            rows_m1;
    logic [COL_BITS-1:0]            cols_m1;

    logic                           cfg_fire;
    logic                           cfg_size_wr;
    logic                           in_fire;
    logic                           all_in;
    logic                           node_take;
    logic                           acc_load;
    logic                           acc_emit;
    t_pos                           emit_pos;
    t_pos                           load_pos;

    logic                           out_free;
    logic                           s2_fire;
    logic                           s2_free;
    logic                           s1_fire;

    logic [VALUE_BITS-1:0]          u_rdata;
    logic [VALUE_BITS-1:0]          m_rdata;
    logic [COL_BITS-1:0]            m_raddr;

    logic signed [VALUE_BITS-1:0]   s1_up;
    logic signed [VALUE_BITS-1:0]   s1_right;
    logic signed [SUM_BITS-1:0]     s1_sum;
    logic signed [LAP_BITS-1:0]     s1_lap;
    logic                           s1_corner;

    logic signed [PROD_BITS-1:0]    s3_prod;
    logic signed [PROD_BITS-1:0]    s3_round;
    logic signed [DELTA_BITS-1:0]   s3_delta;
    logic signed [RES_BITS-1:0]     s3_sum;
    logic signed [VALUE_BITS-1:0]   s3_value;

    // Grid size in use, clamped to the supported range.
    always_comb begin
        rows_used = r_grid_rows;
        if (r_grid_rows < CFG_SIZE_BITS'(SIZE_MIN)) begin
            rows_used = CFG_SIZE_BITS'(SIZE_MIN);
        end else if (r_grid_rows > CFG_SIZE_BITS'(MAX_ROWS)) begin
            rows_used = CFG_SIZE_BITS'(MAX_ROWS);
        end
        cols_used = r_grid_cols;
        if (r_grid_cols < CFG_SIZE_BITS'(SIZE_MIN)) begin
            cols_used = CFG_SIZE_BITS'(SIZE_MIN);
        end else if (r_grid_cols > CFG_SIZE_BITS'(MAX_COLS)) begin
            cols_used = CFG_SIZE_BITS'(MAX_COLS);
        end
    end

    assign rows_m1 = ROW_BITS'(rows_used - CFG_SIZE_BITS'(1));
    assign cols_m1 = COL_BITS'(cols_used - CFG_SIZE_BITS'(1));

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_size_wr = cfg_fire && ((i_cfg_index == REG_GRID_ROWS) ||
                                      (i_cfg_index == REG_GRID_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows      <= CFG_SIZE_BITS'(ROWS_RESET);
            r_grid_cols      <= CFG_SIZE_BITS'(COLS_RESET);
            r_step_gain      <= GAIN_BITS'(GAIN_RESET);
            r_corner_voltage <= VALUE_BITS'(CORNER_RESET);
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_GRID_ROWS:      r_grid_rows      <= i_cfg_data[CFG_SIZE_BITS-1:0];
                REG_GRID_COLS:      r_grid_cols      <= i_cfg_data[CFG_SIZE_BITS-1:0];
                REG_STEP_GAIN:      r_step_gain      <= i_cfg_data[GAIN_BITS-1:0];
                REG_CORNER_VOLTAGE: r_corner_voltage <= $signed(i_cfg_data[VALUE_BITS-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Request classification. The first row only fills the middle line; a node request
    // from the second node of the second row on completes the window of one result.
    assign in_fire   = i_in_valid && o_in_ready;
    assign all_in    = r_in_row > {1'b0, rows_m1};
    assign node_take = (i_opcode == OP_NODE) && !all_in;
    assign acc_load  = node_take && (r_in_row == '0);
    assign acc_emit  = (node_take && (r_in_row != '0) &&
                        !((r_in_row == (ROW_BITS + 1)'(1)) && (r_in_col == '0))) ||
                       ((i_opcode == OP_FLUSH) && all_in);

    always_comb begin
        emit_pos.row  = r_out_row;
        emit_pos.col  = r_out_col;
        emit_pos.top  = (r_out_row == '0);
        emit_pos.bot  = (r_out_row == rows_m1);
        emit_pos.lft  = (r_out_col == '0);
        emit_pos.rgt  = (r_out_col == cols_m1);
        emit_pos.last = emit_pos.bot && emit_pos.rgt;

        load_pos      = '0;
        load_pos.col  = r_in_col;
        load_pos.lft  = (r_in_col == '0);
    end

    // Counter and window update.
    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_window  = r_window;
        if (cfg_size_wr) begin
            n_in_row  = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end else if (in_fire) begin
            if (node_take) begin
                n_window = i_node_value;
                if (r_in_col == cols_m1) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + (ROW_BITS + 1)'(1);
                end else begin
                    n_in_col = r_in_col + COL_BITS'(1);
                end
            end
            if (acc_emit) begin
                if (emit_pos.last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end else if (emit_pos.rgt) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_BITS'(1);
                end else begin
                    n_out_col = r_out_col + COL_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_window  <= '0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_window  <= n_window;
        end
    end

    // Pipeline flow control.
    assign out_free   = !r_o_valid || i_out_ready;
    assign s2_fire    = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_fire    = r_s1_valid && (!r_s1_emit || s2_free);
    assign o_in_ready = !r_s1_valid || s1_fire;

    // Line buffers. The upper line is read at the node's column; the middle line at the
    // column to the right, or at column zero on the right edge to prefetch the next center.
    assign m_raddr = (r_out_col == cols_m1) ? '0 : r_out_col + COL_BITS'(1);

    rcgs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_upper_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire && r_s1_emit),
        .i_wr_addr (r_s1_pos.col),
        .i_wr_data (r_next_ctr),
        .i_rd_en   (in_fire && acc_emit),
        .i_rd_addr (r_out_col),
        .o_rd_data (u_rdata)
    );

    rcgs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_COLS)
    ) u_middle_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_pos.col),
        .i_wr_data (r_s1_val),
        .i_rd_en   (in_fire && acc_emit),
        .i_rd_addr (m_raddr),
        .o_rd_data (m_rdata)
    );

    // Stage 1 register: a row-zero load or a node to produce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_fire && (acc_load || acc_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && o_in_ready) begin
            r_s1_emit <= acc_emit;
            r_s1_pos  <= acc_emit ? emit_pos : load_pos;
            r_s1_val  <= acc_emit ? r_window : i_node_value;
        end
    end

    // Laplacian. A neighbor outside the grid is left out, the center still counts four.
    assign s1_up     = $signed(u_rdata);
    assign s1_right  = $signed(m_rdata);
    assign s1_corner = (r_s1_pos.top || r_s1_pos.bot) && (r_s1_pos.lft || r_s1_pos.rgt);

    always_comb begin
        s1_sum = '0;
        if (!r_s1_pos.lft) begin
            s1_sum = s1_sum + SUM_BITS'(r_prev_ctr);
        end
        if (!r_s1_pos.rgt) begin
            s1_sum = s1_sum + SUM_BITS'(s1_right);
        end
        if (!r_s1_pos.top) begin
            s1_sum = s1_sum + SUM_BITS'(s1_up);
        end
        if (!r_s1_pos.bot) begin
            s1_sum = s1_sum + SUM_BITS'(r_s1_val);
        end
        s1_lap = LAP_BITS'(s1_sum) - (LAP_BITS'(r_next_ctr) <<< 2);
    end

    // Center tracking: the right neighbor read now is the next node's center, and the
    // center used now is the next node's left neighbor.
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            if (r_s1_emit) begin
                r_next_ctr <= s1_right;
                r_prev_ctr <= r_next_ctr;
            end else if (r_s1_pos.lft) begin
                r_next_ctr <= r_s1_val;
            end
        end
    end

    // Stage 2 register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_fire && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && s1_fire && r_s1_emit) begin
            r_s2_lap    <= s1_lap;
            r_s2_ctr    <= r_next_ctr;
            r_s2_corner <= s1_corner;
            r_s2_row    <= r_s1_pos.row;
            r_s2_col    <= r_s1_pos.col;
            r_s2_last   <= r_s1_pos.last;
        end
    end

    // Gain multiply, round half up, add to the center and saturate; a corner takes the corner voltage.
    always_comb begin
        s3_prod  = $signed({1'b0, r_step_gain}) * r_s2_lap;
        s3_round = s3_prod + ROUND_HALF;
        s3_delta = s3_round[PROD_BITS-1:FRAC_BITS];
        s3_sum   = RES_BITS'(r_s2_ctr) + RES_BITS'(s3_delta);
        if (r_s2_corner) begin
            s3_value = r_corner_voltage;
        end else if (s3_sum > SAT_HI) begin
            s3_value = SAT_HI[VALUE_BITS-1:0];
        end else if (s3_sum < SAT_LO) begin
            s3_value = SAT_LO[VALUE_BITS-1:0];
        end else begin
            s3_value = s3_sum[VALUE_BITS-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= s2_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_o_value <= s3_value;
            r_o_row   <= r_s2_row;
            r_o_col   <= r_s2_col;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_new_value  = r_o_value;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_frame_last = r_o_last;

    // The output column counter never runs past the grid width.
    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_col <= cols_m1)
        else $error("output column counter beyond grid width");

    // A node request never completes the last node of the grid; only a flush does.
    a_last_by_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && acc_emit && (i_opcode == OP_NODE)) |-> !emit_pos.last)
        else $error("node request produced the last grid node");

    // The input side only stalls while stage 1 holds a request.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s1_emit && r_s2_valid))
        else $error("input stalled with an empty pipeline");

    // The frame end marker sits on the bottom-right node.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |-> ((r_o_row == rows_m1) && (r_o_col == cols_m1)))
        else $error("frame end marker off the last node");

endmodule

// ===== rtl/rcgs_ram.sv =====
module rcgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port; the read data is registered and holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
